FILE: src/lpc_pkg.sv
package lpc_pkg;

    localparam int MAX_COLS_DEF        = 2048;
    localparam int MAX_ROWS_DEF        = 512;
    localparam int POINT_FRAC_BITS_DEF = 8;

    localparam int COORD_W     = 24;
    localparam int COEF_W      = 32;
    localparam int PROD_W      = COEF_W + COORD_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int NUM_PAIRS   = 6;
    localparam int PIX_W       = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd7;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_POINT = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [10:0]               pixel_col;
        logic [8:0]                pixel_row;
        logic [7:0]                pixel_blue;
        logic [7:0]                pixel_green;
        logic [7:0]                pixel_red;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      cloud_last;
    } t_in_item;

    typedef struct packed {
        logic                      kept;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [7:0]                color_red;
        logic [7:0]                color_green;
        logic [7:0]                color_blue;
        logic                      end_of_cloud;
    } t_out_item;

    typedef struct packed {
        logic [NUM_PAIRS-1:0][CFG_DATA_W-1:0] pair;
        logic [11:0]                          image_width;
        logic [9:0]                           image_height;
    } t_cfg;

    typedef struct packed {
        t_in_item                item;
        logic signed [SUM_W-1:0] u;
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] w;
    } t_qitem;

endpackage

FILE: src/lidar_point_camera_colorizer.sv
// Stages: 3 front stages, the queue, then 3 + QW + 3 back stages, where
//   QW = clog2(max(MAX_COLS, MAX_ROWS)) + 1 is the quotient width.
// Throughput: one request per cycle unless stalled, pixel loads and points alike; the
//   divider is a QW-stage restoring pipeline; frame store: one read and one write port.
// Reset: synchronous, active low; clears pipeline valids, queue pointers and the
//   registers (matrix 0, width 2048, height 512). The frame store is not cleared.
module lidar_point_camera_colorizer #(
    parameter int MAX_COLS        = lpc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS        = lpc_pkg::MAX_ROWS_DEF,
    parameter int POINT_FRAC_BITS = lpc_pkg::POINT_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  lpc_pkg::t_in_item                i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output lpc_pkg::t_out_item               o_item
);

    lpc_pkg::t_cfg   r_cfg;
    logic            q_full, q_push, q_valid, q_pop;
    lpc_pkg::t_qitem q_in, q_out;

    // register file: to be written only while idle; the user must keep to this, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pair         <= '0;
            r_cfg.image_width  <= 12'd2048;
            r_cfg.image_height <= 10'd512;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpc_pkg::CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data[11:0];
                lpc_pkg::CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data[9:0];
                default:                   r_cfg.pair[i_cfg_idx] <= i_cfg_data;
            endcase
        end
    end

    // front: accept request, form u, v, w
    lpc_front #(
        .POINT_FRAC_BITS (POINT_FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_qitem  (q_in)
    );

    // decouple front and back so each can stall on its own
    lpc_queue #(
        .DEPTH (lpc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_out)
    );

    // back: divide, test bounds, access the frame store, drive results
    lpc_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_qitem   (q_out),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

endmodule

FILE: src/lpc_ram.sv
module lpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: src/lpc_front.sv
module lpc_front #(
    parameter int POINT_FRAC_BITS = lpc_pkg::POINT_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpc_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  lpc_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_push,
    output lpc_pkg::t_qitem   o_qitem
);

    logic adv;

    logic              r_f0_v, r_f1_v, r_f2_v;
    lpc_pkg::t_in_item r_f0_item, r_f1_item, r_f2_item;

    logic signed [lpc_pkg::PROD_W-1:0] r_p [3][3];
    logic signed [lpc_pkg::SUM_W-1:0]  r_k [3];
    logic signed [lpc_pkg::SUM_W-1:0]  r_s [3];

    logic signed [lpc_pkg::PROD_W-1:0] n_p [3][3];
    logic signed [lpc_pkg::SUM_W-1:0]  n_k [3];
    logic signed [lpc_pkg::SUM_W-1:0]  n_s [3];

    assign adv     = !i_q_full;
    assign o_ready = adv;
    assign o_push  = r_f2_v && adv;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            logic signed [lpc_pkg::COEF_W-1:0] c0, c1, c2, c3;
            c0 = i_cfg.pair[r*2][lpc_pkg::COEF_W-1:0];
            c1 = i_cfg.pair[r*2][2*lpc_pkg::COEF_W-1:lpc_pkg::COEF_W];
            c2 = i_cfg.pair[r*2+1][lpc_pkg::COEF_W-1:0];
            c3 = i_cfg.pair[r*2+1][2*lpc_pkg::COEF_W-1:lpc_pkg::COEF_W];
            n_p[r][0] = lpc_pkg::PROD_W'(c0) * lpc_pkg::PROD_W'(r_f0_item.point_x);
            n_p[r][1] = lpc_pkg::PROD_W'(c1) * lpc_pkg::PROD_W'(r_f0_item.point_y);
            n_p[r][2] = lpc_pkg::PROD_W'(c2) * lpc_pkg::PROD_W'(r_f0_item.point_z);
            // homogeneous one carries the point's fraction bits
            n_k[r] = lpc_pkg::SUM_W'(c3) <<< POINT_FRAC_BITS;
            n_s[r] = lpc_pkg::SUM_W'(r_p[r][0]) + lpc_pkg::SUM_W'(r_p[r][1])
                   + lpc_pkg::SUM_W'(r_p[r][2]) + r_k[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_v <= 1'b0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (adv) begin
            r_f0_v <= i_valid;
            r_f1_v <= r_f0_v;
            r_f2_v <= r_f1_v;
        end
        if (adv) begin
            r_f0_item <= i_item;
            r_f1_item <= r_f0_item;
            r_f2_item <= r_f1_item;
            r_p       <= n_p;
            r_k       <= n_k;
            r_s       <= n_s;
        end
    end

    always_comb begin
        o_qitem.item = r_f2_item;
        o_qitem.u    = r_s[0];
        o_qitem.v    = r_s[1];
        o_qitem.w    = r_s[2];
    end

endmodule

FILE: src/lpc_queue.sv
module lpc_queue #(
    parameter int DEPTH = lpc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpc_pkg::t_qitem i_data,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output lpc_pkg::t_qitem o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lpc_pkg::t_qitem r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            pop_ok;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_data  = r_mem[r_rp];
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && pop_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/lpc_back.sv
module lpc_back #(
    parameter int MAX_COLS = lpc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lpc_pkg::MAX_ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpc_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  lpc_pkg::t_qitem    i_qitem,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output lpc_pkg::t_out_item o_item
);

    localparam int MAXD  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int QW    = $clog2(MAXD) + 1;
    localparam int NW    = lpc_pkg::SUM_W + 2;
    localparam int RW    = NW + QW;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADW   = $clog2(DEPTH);

    typedef struct packed {
        lpc_pkg::t_in_item item;
        logic              rej;
        logic              su;
        logic              sv;
    } t_bmeta;

    logic en;

    // magnitude stage
    logic                     r_b0_v;
    t_bmeta                   r_b0_m;
    logic [lpc_pkg::SUM_W-1:0] r_b0_au, r_b0_av, r_b0_aw;
    // numerator / denominator stage
    logic          r_b1_v;
    t_bmeta        r_b1_m;
    logic [NW-1:0] r_b1_nu, r_b1_nv, r_b1_d;
    // divider stages, element 0 holds the overflow check
    logic          r_dv_v   [QW+1];
    t_bmeta        r_dv_m   [QW+1];
    logic          r_dv_ovu [QW+1];
    logic          r_dv_ovv [QW+1];
    logic [RW-1:0] r_dv_ru  [QW+1];
    logic [RW-1:0] r_dv_rv  [QW+1];
    logic [QW-1:0] r_dv_qu  [QW+1];
    logic [QW-1:0] r_dv_qv  [QW+1];
    logic [NW-1:0] r_dv_d   [QW+1];
    logic [RW-1:0] n_ru [QW];
    logic [RW-1:0] n_rv [QW];
    logic [QW-1:0] n_qu [QW];
    logic [QW-1:0] n_qv [QW];
    // check / address stage
    logic              r_c_v, r_c_kept, r_c_we;
    lpc_pkg::t_in_item r_c_item;
    logic [ADW-1:0]    r_c_addr;
    // read stage
    logic              r_d_v, r_d_kept;
    lpc_pkg::t_in_item r_d_item;
    logic [lpc_pkg::PIX_W-1:0] ram_q;
    // output stage
    logic               r_e_v;
    lpc_pkg::t_out_item r_e_out;

    logic              n_kept, n_we;
    logic [ADW-1:0]    n_addr;
    logic [QW-1:0]     fq_u, fq_v;
    lpc_pkg::t_in_item fi;

    assign en      = !r_e_v || i_ready;
    assign o_pop   = en && i_q_valid;
    assign o_valid = r_e_v;
    assign o_item  = r_e_out;

    function automatic logic [lpc_pkg::SUM_W-1:0] mag(input logic signed [lpc_pkg::SUM_W-1:0] a);
        return a[lpc_pkg::SUM_W-1] ? lpc_pkg::SUM_W'(-a) : lpc_pkg::SUM_W'(a);
    endfunction

    always_comb begin
        for (int s = 0; s < QW; s++) begin
            logic [RW-1:0] tu;
            tu = RW'(r_dv_d[s]) << (QW - 1 - s);
            n_ru[s] = r_dv_ru[s];
            n_rv[s] = r_dv_rv[s];
            n_qu[s] = r_dv_qu[s];
            n_qv[s] = r_dv_qv[s];
            if (r_dv_ru[s] >= tu) begin
                n_ru[s] = r_dv_ru[s] - tu;
                n_qu[s] = r_dv_qu[s] | (QW'(1) << (QW - 1 - s));
            end
            if (r_dv_rv[s] >= tu) begin
                n_rv[s] = r_dv_rv[s] - tu;
                n_qv[s] = r_dv_qv[s] | (QW'(1) << (QW - 1 - s));
            end
        end
    end

    always_comb begin
        fi   = r_dv_m[QW].item;
        fq_u = r_dv_qu[QW];
        fq_v = r_dv_qv[QW];
        n_kept = (fi.opcode == lpc_pkg::OP_POINT) && !r_dv_m[QW].rej
              && !r_dv_ovu[QW] && !r_dv_ovv[QW]
              && !(r_dv_m[QW].su && fq_u != '0) && !(r_dv_m[QW].sv && fq_v != '0)
              && (32'(fq_u) < 32'(i_cfg.image_width)) && (32'(fq_v) < 32'(i_cfg.image_height))
              && (32'(fq_u) < MAX_COLS) && (32'(fq_v) < MAX_ROWS);
        n_we = (fi.opcode == lpc_pkg::OP_PIXEL)
            && (32'(fi.pixel_col) < MAX_COLS) && (32'(fi.pixel_row) < MAX_ROWS);
        if (fi.opcode == lpc_pkg::OP_POINT) begin
            n_addr = ADW'(32'(fq_v) * MAX_COLS + 32'(fq_u));
        end else begin
            n_addr = ADW'(32'(fi.pixel_row) * MAX_COLS + 32'(fi.pixel_col));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
            r_b1_v <= 1'b0;
            for (int s = 0; s <= QW; s++) begin
                r_dv_v[s] <= 1'b0;
            end
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (en) begin
            r_b0_v    <= i_q_valid;
            r_b1_v    <= r_b0_v;
            r_dv_v[0] <= r_b1_v;
            for (int s = 0; s < QW; s++) begin
                r_dv_v[s+1] <= r_dv_v[s];
            end
            r_c_v <= r_dv_v[QW];
            r_d_v <= r_c_v;
            r_e_v <= r_d_v && (r_d_item.opcode == lpc_pkg::OP_POINT);
        end
        if (en) begin
            r_b0_m.item <= i_qitem.item;
            r_b0_m.rej  <= i_qitem.item.point_x[lpc_pkg::COORD_W-1] || (i_qitem.w == '0);
            r_b0_m.su   <= i_qitem.u[lpc_pkg::SUM_W-1] ^ i_qitem.w[lpc_pkg::SUM_W-1];
            r_b0_m.sv   <= i_qitem.v[lpc_pkg::SUM_W-1] ^ i_qitem.w[lpc_pkg::SUM_W-1];
            r_b0_au     <= mag(i_qitem.u);
            r_b0_av     <= mag(i_qitem.v);
            r_b0_aw     <= mag(i_qitem.w);

            // round to nearest: (2|n| + |d|) / (2|d|)
            r_b1_m  <= r_b0_m;
            r_b1_nu <= (NW'(r_b0_au) << 1) + NW'(r_b0_aw);
            r_b1_nv <= (NW'(r_b0_av) << 1) + NW'(r_b0_aw);
            r_b1_d  <= NW'(r_b0_aw) << 1;

            r_dv_m[0]   <= r_b1_m;
            r_dv_ovu[0] <= RW'(r_b1_nu) >= (RW'(r_b1_d) << QW);
            r_dv_ovv[0] <= RW'(r_b1_nv) >= (RW'(r_b1_d) << QW);
            r_dv_ru[0]  <= RW'(r_b1_nu);
            r_dv_rv[0]  <= RW'(r_b1_nv);
            r_dv_qu[0]  <= '0;
            r_dv_qv[0]  <= '0;
            r_dv_d[0]   <= r_b1_d;
            for (int s = 0; s < QW; s++) begin
                r_dv_m[s+1]   <= r_dv_m[s];
                r_dv_ovu[s+1] <= r_dv_ovu[s];
                r_dv_ovv[s+1] <= r_dv_ovv[s];
                r_dv_ru[s+1]  <= n_ru[s];
                r_dv_rv[s+1]  <= n_rv[s];
                r_dv_qu[s+1]  <= n_qu[s];
                r_dv_qv[s+1]  <= n_qv[s];
                r_dv_d[s+1]   <= r_dv_d[s];
            end

            r_c_item <= fi;
            r_c_kept <= n_kept;
            r_c_we   <= n_we;
            r_c_addr <= n_addr;

            r_d_item <= r_c_item;
            r_d_kept <= r_c_kept;

            r_e_out.kept         <= r_d_kept;
            r_e_out.out_x        <= r_d_item.point_x;
            r_e_out.out_y        <= r_d_item.point_y;
            r_e_out.out_z        <= r_d_item.point_z;
            r_e_out.color_red    <= r_d_kept ? ram_q[23:16] : 8'd0;
            r_e_out.color_green  <= r_d_kept ? ram_q[15:8]  : 8'd0;
            r_e_out.color_blue   <= r_d_kept ? ram_q[7:0]   : 8'd0;
            r_e_out.end_of_cloud <= r_d_item.cloud_last;
        end
    end

    lpc_ram #(
        .WIDTH (lpc_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (en && r_c_v && r_c_we),
        .i_waddr (r_c_addr),
        .i_wdata ({r_c_item.pixel_red, r_c_item.pixel_green, r_c_item.pixel_blue}),
        .i_rd_en (en),
        .i_raddr (r_c_addr),
        .o_rdata (ram_q)
    );

endmodule

FILE: tb/tb_lidar_point_camera_colorizer.sv
module tb_lidar_point_camera_colorizer;
    timeunit 1ns;
    timeprecision 1ps;

    import lpc_pkg::*;

    localparam int STORE_COLS = MAX_COLS_DEF;
    localparam int STORE_ROWS = MAX_ROWS_DEF;
    localparam int DRAIN_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    t_in_item              i_item;
    logic                  o_valid;
    logic                  i_ready;
    t_out_item             o_item;

    lidar_point_camera_colorizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

    // Shadow copy of the registers; changed only while the block is idle.
    logic [CFG_DATA_W-1:0] mat_pair [NUM_PAIRS];
    int unsigned           img_width;
    int unsigned           img_height;

    // Pixels the stimulus has queued for loading, and the colors the block has accepted.
    bit                pix_loaded [int unsigned];
    logic [PIX_W-1:0]  frame_mem  [int unsigned];

    t_in_item  pending_reqs [$];
    t_out_item colored_points [$];

    int  errors;
    bit  quiet;
    int  send_gap;
    int  recv_stall;

    initial begin
        i_clk = 1'b0;
    end
    always #4 i_clk = ~i_clk;

    function automatic longint coef(int r, int i);
        logic [CFG_DATA_W-1:0] pair;
        logic [31:0]           wd;
        pair = mat_pair[r * 2 + i / 2];
        wd = (i % 2 == 1) ? pair[63:32] : pair[31:0];
        return longint'($signed(wd));
    endfunction

    function automatic longint dot_row(int r, longint x, longint y, longint z);
        return coef(r, 0) * x + coef(r, 1) * y + coef(r, 2) * z
            + coef(r, 3) * (longint'(1) << POINT_FRAC_BITS_DEF);
    endfunction

    // Rounded quotient, ties away from zero; fails on a nonzero negative result.
    function automatic bit round_index(longint n, longint d, output longint unsigned q);
        longint unsigned an, ad;
        an = (n < 0) ? longint'(-n) : n;
        ad = (d < 0) ? longint'(-d) : d;
        q = (2 * an + ad) / (2 * ad);
        return !(((n < 0) != (d < 0)) && q != 0);
    endfunction

    // Project a point; return whether it lands inside the image, and where.
    function automatic bit project(t_in_item it, output int unsigned col,
                                   output int unsigned row);
        longint x, y, z, u, v, w;
        longint unsigned qc, qr;
        col = 0;
        row = 0;
        x = longint'($signed(it.point_x));
        y = longint'($signed(it.point_y));
        z = longint'($signed(it.point_z));
        if (x < 0)
            return 1'b0;
        u = dot_row(0, x, y, z);
        v = dot_row(1, x, y, z);
        w = dot_row(2, x, y, z);
        if (w == 0)
            return 1'b0;
        if (!round_index(u, w, qc) || !round_index(v, w, qr))
            return 1'b0;
        if (qc >= img_width || qr >= img_height || qc >= STORE_COLS || qr >= STORE_ROWS)
            return 1'b0;
        col = 32'(qc);
        row = 32'(qr);
        return 1'b1;
    endfunction

    // Apply one accepted request to the shadow store and, for a point, queue its colored point.
    task automatic colorize(t_in_item it);
        t_out_item   res;
        int unsigned col, row;
        logic [PIX_W-1:0] px;
        if (it.opcode == OP_PIXEL) begin
            frame_mem[it.pixel_row * STORE_COLS + it.pixel_col] =
                {it.pixel_red, it.pixel_green, it.pixel_blue};
            return;
        end
        px = '0;
        res.kept = project(it, col, row);
        if (res.kept && frame_mem.exists(row * STORE_COLS + col))
            px = frame_mem[row * STORE_COLS + col];
        res.out_x = it.point_x;
        res.out_y = it.point_y;
        res.out_z = it.point_z;
        res.color_red = px[23:16];
        res.color_green = px[15:8];
        res.color_blue = px[7:0];
        res.end_of_cloud = it.cloud_last;
        colored_points = {colored_points, res};
    endtask

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Driver: present queued requests, with random bursts of idle cycles unless quiet.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && o_ready)
                colorize(i_item);
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(0, 11);
                        i_valid <= 1'b0;
                    end else begin
                        i_valid <= 1'b1;
                        i_item <= pending_reqs.pop_front();
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result and stall the output at random unless quiet.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (colored_points.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, o_item);
                    errors++;
                end else begin
                    exp_r = colored_points.pop_front();
                    check_field("kept", exp_r.kept, o_item.kept);
                    check_field("out_x", exp_r.out_x, o_item.out_x);
                    check_field("out_y", exp_r.out_y, o_item.out_y);
                    check_field("out_z", exp_r.out_z, o_item.out_z);
                    check_field("color_red", exp_r.color_red, o_item.color_red);
                    check_field("color_green", exp_r.color_green, o_item.color_green);
                    check_field("color_blue", exp_r.color_blue, o_item.color_blue);
                    check_field("end_of_cloud", exp_r.end_of_cloud, o_item.end_of_cloud);
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_stall = $urandom_range(0, 11);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_IDX_W'(idx);
        i_cfg_data <= data;
        if (idx < NUM_PAIRS)
            mat_pair[idx] = data;
        else if (CFG_IDX_W'(idx) == CFG_IMAGE_WIDTH)
            img_width = 32'(data[11:0]);
        else
            img_height = 32'(data[9:0]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Pinhole-like camera: col = cx + f*y/x, row = cy + f*z/x, w = x.
    task automatic set_camera(int cx, int cy, int f, int wd, int ht);
        logic [31:0] one_q, cx_q, cy_q, f_q;
        one_q = 32'h0001_0000;
        cx_q = cx << 16;
        cy_q = cy << 16;
        f_q = f << 16;
        write_reg(0, {f_q, cx_q});
        write_reg(1, 64'd0);
        write_reg(2, {32'd0, cy_q});
        write_reg(3, {32'd0, f_q});
        write_reg(4, {32'd0, one_q});
        write_reg(5, 64'd0);
        write_reg(CFG_IMAGE_WIDTH, 64'(wd));
        write_reg(CFG_IMAGE_HEIGHT, 64'(ht));
    endtask

    task automatic push_pixel(int col, int row, logic [23:0] rgb);
        t_in_item     it;
        logic [159:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = rnd[$bits(t_in_item)-1:0];
        it.opcode = OP_PIXEL;
        it.pixel_col = 11'(col);
        it.pixel_row = 9'(row);
        {it.pixel_red, it.pixel_green, it.pixel_blue} = rgb;
        pix_loaded[row * STORE_COLS + col] = 1'b1;
        pending_reqs = {pending_reqs, it};
    endtask

    // Queue a point; load its pixel first if it would hit one never written.
    task automatic push_point(int x, int y, int z, bit last);
        t_in_item     it;
        logic [159:0] rnd;
        int unsigned  col, row;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = rnd[$bits(t_in_item)-1:0];
        it.opcode = OP_POINT;
        it.point_x = 24'(x);
        it.point_y = 24'(y);
        it.point_z = 24'(z);
        it.cloud_last = last;
        if (project(it, col, row) && !pix_loaded.exists(row * STORE_COLS + col))
            push_pixel(col, row, 24'($urandom));
        pending_reqs = {pending_reqs, it};
    endtask

    // Point aimed near the image; offsets slightly overshoot the edges.
    task automatic push_aimed_point(int f);
        int x, dc, dr;
        x = $urandom_range(1, 4000);
        dc = $urandom_range(0, 2 * 2052) - 2052;
        dr = $urandom_range(0, 2 * 1030) - 1030;
        if ($urandom_range(0, 19) == 0)
            x = -x;
        push_point(x, (x * dc) / f, (x * dr) / f, $urandom_range(0, 7) == 0);
    endtask

    // Hold until the block has drained, then allow loads to settle.
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || i_valid || colored_points.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    int wd, ht, f;

    initial begin
        errors = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_item = '0;
        for (int i = 0; i < NUM_PAIRS; i++)
            mat_pair[i] = '0;
        img_width = STORE_COLS;
        img_height = STORE_ROWS;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset matrix is all zero: w is zero for every point.
        push_point(0, 0, 0, 1'b0);
        push_point(24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, 1'b1);
        push_point(-24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        push_point(-1, -1, -1, 1'b1);
        wait_idle();

        // Oversized image registers, corners of the store, extreme colors.
        set_camera(2047, 511, 1, 4095, 1023);
        push_pixel(2047, 511, 24'hFFFFFF);
        push_pixel(0, 0, 24'h000000);
        push_pixel(2047, 0, 24'hA5C30F);
        push_point(256, 0, 0, 1'b1);
        push_point(256, 256, 0, 1'b0);
        push_point(256, 0, 256, 1'b0);
        push_point(256, -2047 * 256, -511 * 256, 1'b1);
        push_point(256, 0, -511 * 256, 1'b0);
        push_point(0, 0, 0, 1'b0);
        push_point(-256, 0, 0, 1'b1);
        wait_idle();

        // Negative quotient: rounding to zero is column zero, beyond is outside.
        set_camera(0, 0, 1, 2048, 512);
        push_point(256, -127, -128, 1'b0);
        push_point(256, -128, 0, 1'b0);
        push_point(256, 128, 127, 1'b1);
        push_point(256, -129, 0, 1'b0);
        wait_idle();

        // Zero width and height keep nothing.
        set_camera(5, 5, 1, 0, 0);
        push_point(256, 0, 0, 1'b0);
        push_point(300, 10, 10, 1'b1);
        wait_idle();

        // Random phases: mostly aimed points, some loads and raw noise.
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 5))
                0: wd = 1;
                1: wd = 4095;
                2: wd = 0;
                default: wd = $urandom_range(1, 2048);
            endcase
            case ($urandom_range(0, 5))
                0: ht = 1;
                1: ht = 1023;
                2: ht = 512;
                default: ht = $urandom_range(1, 512);
            endcase
            f = $urandom_range(1, 64);
            if (ph == 3 || ph == 7) begin
                for (int r = 0; r < NUM_PAIRS; r++)
                    write_reg(r, {$urandom, $urandom});
                write_reg(CFG_IMAGE_WIDTH, 64'(wd));
                write_reg(CFG_IMAGE_HEIGHT, 64'(ht));
            end else begin
                set_camera($urandom_range(0, 2047), $urandom_range(0, 511), f, wd, ht);
            end
            quiet = (ph == 9);
            for (int n = 0; n < 180; n++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2:
                        push_pixel($urandom_range(0, 2047), $urandom_range(0, 511),
                                   24'($urandom));
                    3, 4:
                        push_point($urandom, $urandom, $urandom, $urandom_range(0, 1));
                    default:
                        push_aimed_point(f);
                endcase
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
src/lpc_pkg.sv
src/lpc_ram.sv
src/lpc_front.sv
src/lpc_queue.sv
src/lpc_back.sv
src/lidar_point_camera_colorizer.sv
tb/tb_lidar_point_camera_colorizer.sv
